// File: hw/rtl/shfd_pkg.sv
// Shared constants and types for the sync header frame deframer.
// No dependencies; imported by every module of the block.

package shfd_pkg;

   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned WORD_W          = 32;
   localparam int unsigned POS_W           = 5;
   localparam int unsigned HEADER_BYTES    = 2;
   localparam int unsigned PAYLOAD_BYTES   = 16;
   localparam int unsigned STORE_ADDR_W    = $clog2(PAYLOAD_BYTES);
   localparam int unsigned FRAME_LENGTH_DEF = 19;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'h55;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'hAA;

   localparam int unsigned        CSR_INDEX_W      = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND = 2'd1;

   // Per-byte command from the framing FSM to the payload store.
   typedef struct packed {
      logic                    wr_en;
      logic [STORE_ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0]       wr_data;
      logic                    frame_done;
   } shfd_cmd_type;

endpackage

// File: hw/rtl/sync_header_frame_deframer.sv
// Sync header deframer: one byte per cycle, result in the cycle after the last byte.
// Throughput 1 byte/cycle; the byte input stalls only on a frame's last byte while
// the result register still holds an untaken word. Frame is FRAME_LENGTH bytes.
// Synchronous reset: back to hunting, result register empty, sync bytes 0x55/0xAA.
// Payload store is not reset. Depends on shfd_pkg, shfd_ctrl, shfd_store.

module sync_header_frame_deframer
   import shfd_pkg::*;
#(
   parameter int unsigned FRAME_LENGTH = FRAME_LENGTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WORD_W-1:0]      rsp_x_bits,
   output logic [WORD_W-1:0]      rsp_y_bits,
   output logic [WORD_W-1:0]      rsp_z_bits,
   output logic [WORD_W-1:0]      rsp_w_bits,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_wdata
);

   logic [BYTE_W-1:0] sync_first_ff, sync_second_ff;
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] x_ff, y_ff, z_ff, w_ff;
   logic [WORD_W-1:0] x_word, y_word, z_word, w_word;
   logic              accept, frame_end;
   shfd_cmd_type      cmd;

   assign req_stall = rsp_valid_ff && rsp_stall && frame_end;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata;
            CSR_SYNC_SECOND: sync_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   shfd_ctrl #(
      .FRAME_LENGTH (FRAME_LENGTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .sync_first  (sync_first_ff),
      .sync_second (sync_second_ff),
      .cmd         (cmd),
      .frame_end   (frame_end)
   );

   shfd_store u_store (
      .clock  (clock),
      .cmd    (cmd),
      .x_word (x_word),
      .y_word (y_word),
      .z_word (z_word),
      .w_word (w_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.frame_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // last byte is not payload for FRAME_LENGTH > 18, so the store is complete here
   always_ff @(posedge clock) begin
      if (cmd.frame_done) begin
         x_ff <= x_word;
         y_ff <= y_word;
         z_ff <= z_word;
         w_ff <= w_word;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_x_bits = x_ff;
   assign rsp_y_bits = y_ff;
   assign rsp_z_bits = z_ff;
   assign rsp_w_bits = w_ff;

endmodule

// File: hw/rtl/shfd_ctrl.sv
// Framing FSM: sync pair hunt, byte position counter, payload write commands.
// Depends on shfd_pkg.

module shfd_ctrl
   import shfd_pkg::*;
#(
   parameter int unsigned FRAME_LENGTH = FRAME_LENGTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic [BYTE_W-1:0] sync_first,
   input  logic [BYTE_W-1:0] sync_second,
   output shfd_cmd_type      cmd,
   output logic              frame_end
);

   localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_LENGTH - 1);
   localparam logic [POS_W-1:0] HDR_POS     = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] PAYLOAD_END = POS_W'(HEADER_BYTES + PAYLOAD_BYTES);

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_WAIT = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] payload_off;

   assign payload_off = pos_ff - HDR_POS;
   // depends on state only, so the top can stall ahead of a frame's last byte
   assign frame_end   = (phase_ff == PH_BODY) && (pos_ff >= LAST_POS);

   always_comb begin
      phase_in        = phase_ff;
      pos_in          = pos_ff;
      cmd.wr_en       = 1'b0;
      cmd.wr_addr     = payload_off[STORE_ADDR_W-1:0];
      cmd.wr_data     = rx_byte;
      cmd.frame_done  = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_BODY: begin
               cmd.wr_en = (pos_ff >= HDR_POS) && (pos_ff < PAYLOAD_END);
               if (pos_ff >= LAST_POS) begin
                  cmd.frame_done = 1'b1;
                  phase_in       = PH_HUNT;
                  pos_in         = '0;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
            PH_WAIT: begin
               // second byte is tested first so equal sync values still frame
               if (rx_byte == sync_second) begin
                  phase_in = PH_BODY;
                  pos_in   = HDR_POS;
               end else if (rx_byte != sync_first) begin
                  phase_in = PH_HUNT;
                  pos_in   = '0;
               end
            end
            default: begin
               if (rx_byte == sync_first) begin
                  phase_in = PH_WAIT;
                  pos_in   = POS_W'(1);
               end else begin
                  phase_in = PH_HUNT;
                  pos_in   = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// File: hw/rtl/shfd_store.sv
// Sixteen-byte payload store and little-endian word assembly.
// Depends on shfd_pkg.

module shfd_store
   import shfd_pkg::*;
(
   input  logic              clock,
   input  shfd_cmd_type      cmd,
   output logic [WORD_W-1:0] x_word,
   output logic [WORD_W-1:0] y_word,
   output logic [WORD_W-1:0] z_word,
   output logic [WORD_W-1:0] w_word
);

   logic [BYTE_W-1:0] store_ff [PAYLOAD_BYTES];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_ff[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   assign x_word = {store_ff[3],  store_ff[2],  store_ff[1],  store_ff[0]};
   assign y_word = {store_ff[7],  store_ff[6],  store_ff[5],  store_ff[4]};
   assign z_word = {store_ff[11], store_ff[10], store_ff[9],  store_ff[8]};
   assign w_word = {store_ff[15], store_ff[14], store_ff[13], store_ff[12]};

endmodule

// File: hw/rtl/shfd_checker.sv
// Port-level checks for the sync header deframer, bound to the top level.
// Depends on shfd_pkg and sync_header_frame_deframer.

module shfd_checker
   import shfd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [WORD_W-1:0] rsp_x_bits,
   input logic [WORD_W-1:0] rsp_y_bits,
   input logic [WORD_W-1:0] rsp_z_bits,
   input logic [WORD_W-1:0] rsp_w_bits
);

   // a held result word keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_x_bits) && $stable(rsp_y_bits)
         && $stable(rsp_z_bits) && $stable(rsp_w_bits))
      else $error("result word changed while stalled");

   // input only backs up behind a blocked result
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a new result is always caused by an accepted byte
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result appeared without an accepted byte");

endmodule

bind sync_header_frame_deframer shfd_checker u_shfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_x_bits (rsp_x_bits),
   .rsp_y_bits (rsp_y_bits),
   .rsp_z_bits (rsp_z_bits),
   .rsp_w_bits (rsp_w_bits)
);
